// ===== sv/multi_tap_keypad_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-tap keypad decoder.
// Each macro checks one property on the rising clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_TAP_KEYPAD_DECODER_ASSERT_SVH
`define MULTI_TAP_KEYPAD_DECODER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define MTKD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtkd same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define MTKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtkd next-cycle check failed");

`endif

// ===== sv/mtkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtkd_pkg
// Types, constants and table functions shared by the keypad decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtkd_pkg;

  // One input beat.
  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_of_step;
  } out_beat_t;

  // Results produced by one input item; a second result only follows a first.
  typedef struct packed {
    logic      a_valid;
    logic      b_valid;
    out_beat_t a;
    out_beat_t b;
  } step_res_t;

  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [7:0] SYM_ONE   = 8'h31;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_HASH  = 8'h23;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic [3:0] KEY_ZERO = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;
  localparam logic [3:0] KEY_NONE = 4'd15;

  localparam int ROW_SLOTS = 6;

  localparam logic [7:0] KEY_ROWS [0:15][0:ROW_SLOTS-1] = '{
    '{8'h2E, 8'h2C, 8'h2D, 8'h3F, 8'h21, 8'h31},
    '{8'h41, 8'h42, 8'h43, 8'h32, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h46, 8'h33, 8'h00, 8'h00},
    '{8'h47, 8'h48, 8'h49, 8'h34, 8'h00, 8'h00},
    '{8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h00, 8'h00},
    '{8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h00, 8'h00},
    '{8'h50, 8'h51, 8'h52, 8'h53, 8'h37, 8'h00},
    '{8'h54, 8'h55, 8'h56, 8'h38, 8'h00, 8'h00},
    '{8'h57, 8'h58, 8'h59, 8'h5A, 8'h39, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h20, 8'h23, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] ROW_LEN [0:15] = '{
    3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4,
    3'd5, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1
  };

  // Maps a keypad byte to its row index, or KEY_NONE.
  function automatic logic [3:0] key_index(input logic [7:0] sym);
    logic [7:0] diff;
    diff = sym - SYM_ONE;
    if (sym >= SYM_ONE && sym <= SYM_NINE) begin
      return diff[3:0];
    end else if (sym == SYM_ZERO) begin
      return KEY_ZERO;
    end else if (sym == SYM_HASH) begin
      return KEY_HASH;
    end
    return KEY_NONE;
  endfunction

  // Character at a row position; letters fold to lowercase unless capital.
  function automatic logic [7:0] row_char(input logic [3:0] row, input logic [2:0] pos,
                                          input logic capital);
    logic [2:0] p;
    logic [7:0] c;
    p = (pos >= 3'(ROW_SLOTS)) ? 3'd0 : pos;
    c = KEY_ROWS[row][p];
    if (!capital && c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      c = c | CASE_BIT;
    end
    return c;
  endfunction

endpackage

// ===== sv/mtkd_step.sv =====
// ----------------------------------------------------------------------------
// mtkd_step
// Holds the pending key state and decodes one registered symbol per cycle while fire is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtkd_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  mtkd_pkg::in_beat_t  beat,
  output mtkd_pkg::step_res_t res
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [3:0] pend_key_r, pend_key_nxt;
  logic [2:0] press_cnt_r, press_cnt_nxt;

  logic [3:0] key;
  logic [3:0] next_pos;
  logic       e0_valid, e1_valid;
  logic [7:0] e0_char, e1_char;

  assign key = mtkd_pkg::key_index(beat.symbol);

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_key_nxt   = pend_key_r;
    press_cnt_nxt  = press_cnt_r;
    e0_valid       = 1'b0;
    e0_char        = mtkd_pkg::row_char(pend_key_r, press_cnt_r, 1'b0);
    next_pos       = {1'b0, press_cnt_r} + 4'd1;

    if (key != mtkd_pkg::KEY_NONE) begin
      if (pend_valid_r && pend_key_r == key) begin
        if (next_pos >= {1'b0, mtkd_pkg::ROW_LEN[key]}) begin
          press_cnt_nxt = 3'd0;
        end else begin
          press_cnt_nxt = next_pos[2:0];
        end
      end else begin
        e0_valid       = pend_valid_r;
        pend_valid_nxt = 1'b1;
        pend_key_nxt   = key;
        press_cnt_nxt  = 3'd0;
      end
    end else if (beat.symbol == mtkd_pkg::SYM_STAR) begin
      // A capital marker only acts on a character still being composed.
      e0_char = mtkd_pkg::row_char(pend_key_r, press_cnt_r, 1'b1);
      if (pend_valid_r) begin
        e0_valid       = 1'b1;
        pend_valid_nxt = 1'b0;
        press_cnt_nxt  = 3'd0;
      end
    end else if (pend_valid_r) begin
      e0_valid       = 1'b1;
      pend_valid_nxt = 1'b0;
      press_cnt_nxt  = 3'd0;
    end

    // End of message flushes whatever is pending after the symbol itself.
    e1_char  = mtkd_pkg::row_char(pend_key_nxt, press_cnt_nxt, 1'b0);
    e1_valid = beat.end_of_message && pend_valid_nxt;
    if (e1_valid) begin
      pend_valid_nxt = 1'b0;
      press_cnt_nxt  = 3'd0;
    end
  end

  always_comb begin
    res.a_valid = e0_valid || e1_valid;
    res.b_valid = e0_valid && e1_valid;
    res.a.text_char    = e0_valid ? e0_char : e1_char;
    res.a.last_of_step = !(e0_valid && e1_valid);
    res.b.text_char    = e1_char;
    res.b.last_of_step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_key_r   <= 4'd0;
      press_cnt_r  <= 3'd0;
    end else if (fire) begin
      pend_valid_r <= pend_valid_nxt;
      pend_key_r   <= pend_key_nxt;
      press_cnt_r  <= press_cnt_nxt;
    end
  end

endmodule

// ===== sv/mtkd_fifo.sv =====
// ----------------------------------------------------------------------------
// mtkd_fifo
// Result queue that takes up to two beats per cycle and gives one per cycle while not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtkd_fifo #(
  parameter int DEPTH = mtkd_pkg::RES_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtkd_pkg::step_res_t push_res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output mtkd_pkg::out_beat_t out_beat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtkd_pkg::out_beat_t mem_r [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_b;
  logic          pop;
  logic          wr_a, wr_b;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (count_r != '0);
  assign out_beat  = mem_r[rd_ptr_r];
  assign room      = (count_r <= CW'(DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_a      = push && push_res.a_valid;
  assign wr_b      = push && push_res.b_valid;
  assign wr_ptr_b  = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (wr_b) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_b);
    end else if (wr_a) begin
      wr_ptr_nxt = wr_ptr_b;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(wr_a) + CW'(wr_b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_r[wr_ptr_r] <= push_res.a;
    end
    if (wr_b) begin
      mem_r[wr_ptr_b] <= push_res.b;
    end
  end

endmodule

// ===== sv/multi_tap_keypad_decoder.sv =====
// A symbol beat is decoded from the input register; its results go to the result queue.
// Throughput: one symbol beat per cycle while each causes at most one result and the output
// is not stalled; symbols that cause two results are paced by the one-beat-per-cycle output.
// Reset (rst_n low, synchronous) clears the pending key state, the input register
// and the result queue; no character is pending afterwards.
// ----------------------------------------------------------------------------
// multi_tap_keypad_decoder
// Multi-tap phone keypad text decoder: keypad bytes in, decoded characters out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_tap_keypad_decoder_assert.svh"

module multi_tap_keypad_decoder #(
  parameter int FIFO_DEPTH = mtkd_pkg::RES_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtkd_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output mtkd_pkg::out_beat_t out_beat
);

  // The input register holds one symbol beat. It is decoded against the
  // pending key state in the same cycle, and its results (zero, one or two)
  // are pushed into the result queue when the queue has room for two.
  logic               in_valid_r, in_valid_nxt;
  mtkd_pkg::in_beat_t in_beat_r;

  mtkd_pkg::step_res_t res;
  logic                room;
  logic                advance;
  logic                load;

  assign advance      = in_valid_r && room;
  assign in_stall     = in_valid_r && !room;
  assign load         = in_valid && !in_stall;
  assign in_valid_nxt = load || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Payload needs no reset; it is only looked at while in_valid_r is set.
  always_ff @(posedge clk) begin
    if (load) begin
      in_beat_r <= in_beat;
    end
  end

  // Key state and decode. State moves only when the held beat is consumed.
  mtkd_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .beat  (in_beat_r),
    .res   (res)
  );

  // Result queue, which decouples output stalls from symbol intake.
  mtkd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_res  (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // A second result is only ever produced together with a first one.
  `MTKD_ASSERT_IMPL(a_res_order, clk, rst_n, !res.a_valid, !res.b_valid)
  // When two results come from one symbol, the earlier one is not marked last.
  `MTKD_ASSERT_IMPL(a_last_flag, clk, rst_n, res.b_valid, !res.a.last_of_step)
  // A held beat that could not move on is still there, unchanged, next cycle.
  `MTKD_ASSERT_NEXT(a_hold_beat, clk, rst_n, in_valid_r && !advance,
                    in_valid_r && $stable(in_beat_r))
  // A stalled result is never dropped from the queue.
  `MTKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule
